// ===== src/trial_division_prime_test_defines.svh =====
// Assertion helpers for the trial division prime test.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// Check cons in the same cycle as ante.
`define TDPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define TDPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tdpt_pkg.sv =====
package tdpt_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FIRST_DIVISOR  = 3;
  localparam int unsigned DIVISOR_STEP   = 2;

endpackage

// ===== src/tdpt_div.sv =====
module tdpt_div #(
  parameter int unsigned DATA_WIDTH = tdpt_pkg::DATA_WIDTH_DEF,
  parameter int unsigned DIV_W      = DATA_WIDTH / 2 + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DIV_W-1:0]      divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DIV_W-1:0]      remainder
);

  import tdpt_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  logic                  run_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DATA_WIDTH-1:0] dvd_r;
  logic [DIV_W-1:0]      dsr_r;
  logic [DATA_WIDTH-1:0] quo_r;
  logic [DIV_W-1:0]      rem_r;

  logic [DIV_W:0]        part;
  logic [DIV_W:0]        diff;
  logic                  ge;
  logic [DIV_W-1:0]      rem_nxt;

  // one restoring step: bring down the next dividend bit, try the subtract
  always_comb begin
    part    = {rem_r, dvd_r[DATA_WIDTH-1]};
    diff    = part - {1'b0, dsr_r};
    ge      = (part >= {1'b0, dsr_r});
    rem_nxt = ge ? diff[DIV_W-1:0] : part[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == CNT_W'(DATA_WIDTH - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[DATA_WIDTH-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DATA_WIDTH-2:0], ge};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== src/trial_division_prime_test.sv =====
// Trial division prime test. Each input transaction carries one signed candidate; exactly one
// result transaction follows with bit 0 of out_tdata set when the candidate is prime. Negative
// values, 0, 1 and even values above 2 are answered without the divider. An odd candidate of 3
// or more tries odd divisors from 3 upward; the bit-serial restoring divider produces one quotient
// bit per cycle. With 32-bit data the worst case is about 23170 divisors. One candidate is
// processed at a time; a finished result waits in the output register while the next candidate
// is taken.
module trial_division_prime_test #(
  parameter int unsigned DATA_WIDTH = tdpt_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]     in_tdata,   // [DATA_WIDTH-1:0] candidate
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata   // [0] is_prime
);

  import tdpt_pkg::*;

  `include "trial_division_prime_test_defines.svh"

  localparam int unsigned DIV_W = DATA_WIDTH / 2 + 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_DONE
  } state_t;

  state_t                state_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [DIV_W-1:0]      div_r;
  logic                  res_r;
  logic                  out_tvalid_r;
  logic                  out_prime_r;

  logic [DATA_WIDTH-1:0] cand;
  logic                  in_acc;
  logic                  div_start;
  logic                  div_done;
  logic [DATA_WIDTH-1:0] div_quo;
  logic [DIV_W-1:0]      div_rem;
  logic                  cand_odd_test;

  assign cand          = in_tdata[DATA_WIDTH-1:0];
  assign in_tready     = (state_r == ST_IDLE);
  assign in_acc        = in_tvalid && in_tready;
  assign div_start     = (state_r == ST_START);
  assign cand_odd_test = !cand[DATA_WIDTH-1] && (cand[DATA_WIDTH-2:1] != '0) && cand[0];

  tdpt_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .DIV_W      (DIV_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (value_r),
    .divisor   (div_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tready && (state_r != ST_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            value_r <= cand;
            div_r   <= DIV_W'(FIRST_DIVISOR);
            priority if (cand[DATA_WIDTH-1] || (cand[DATA_WIDTH-1:1] == '0)) begin
              res_r   <= 1'b0;
              state_r <= ST_DONE;
            end else if (cand == DATA_WIDTH'(2)) begin
              res_r   <= 1'b1;
              state_r <= ST_DONE;
            end else if (!cand[0]) begin
              res_r   <= 1'b0;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_START;
            end
          end
        end
        ST_START: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            priority if (DATA_WIDTH'(div_r) > div_quo) begin
              res_r   <= 1'b1;
              state_r <= ST_DONE;
            end else if (div_rem == '0) begin
              res_r   <= 1'b0;
              state_r <= ST_DONE;
            end else begin
              div_r   <= div_r + DIV_W'(DIVISOR_STEP);
              state_r <= ST_START;
            end
          end
        end
        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_prime_r  <= res_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_prime_r};

  `TDPT_ASSERT_NEXT(a_odd_start, in_acc && cand_odd_test, (state_r == ST_START) && (div_r == DIV_W'(FIRST_DIVISOR)), "odd candidate did not start at first divisor")
  `TDPT_ASSERT_SAME(a_div_odd, (state_r == ST_START) || (state_r == ST_WAIT), div_r[0], "trial divisor is even")
  `TDPT_ASSERT_SAME(a_done_wait, div_done, state_r == ST_WAIT, "divider finished outside wait state")

endmodule

// ===== dv/trial_division_prime_test_tb.sv =====
`timescale 1ns / 100ps

module trial_division_prime_test_tb;
  import tdpt_pkg::*;

  localparam int unsigned DW = DATA_WIDTH_DEF;
  localparam int N_DIRECTED = 22;
  localparam int N_PHASES = 4;
  localparam int RANDOM_PER_PHASE = 25;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic [DW-1:0] cand;
    bit            typed;
    bit            verdict;
  } probe_t;

  typedef struct packed {
    logic [DW-1:0] cand;
    bit            is_prime;
  } verdict_t;

  logic          clk;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [7:0]    out_tdata;

  verdict_t pending_verdicts[$];
  probe_t   directed_probes[N_DIRECTED];
  int       mismatch_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  trial_division_prime_test #(
    .DATA_WIDTH(DW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),     // [31:0] candidate
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)    // [0] is_prime
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit trial_divide_verdict(logic [DW-1:0] cand);
    longint unsigned v;
    longint unsigned d;
    bit done;
    bit verdict;
    v = cand;
    done = 1'b0;
    verdict = 1'b0;
    if (cand[DW-1] || v <= 1) begin
      done = 1'b1;
    end else if (v == 2) begin
      verdict = 1'b1;
      done = 1'b1;
    end else if (!cand[0]) begin
      done = 1'b1;
    end
    d = FIRST_DIVISOR;
    while (!done) begin
      if (d > v / d) begin
        verdict = 1'b1;
        done = 1'b1;
      end else if (v % d == 0) begin
        done = 1'b1;
      end else begin
        d += DIVISOR_STEP;
      end
    end
    return verdict;
  endfunction

  // keep large odd values composite with a small factor so each test ends early
  function automatic logic [DW-1:0] random_candidate();
    int unsigned kind;
    int unsigned p;
    int unsigned kmax;
    int unsigned k;
    logic [DW-1:0] v;
    kind = $urandom_range(9);
    case (kind)
      0, 1: begin
        v = $urandom();
        v[DW-1] = 1'b1;
      end
      2: v = $urandom() & 32'h7FFF_FFFE;
      3: begin
        case ($urandom_range(4))
          0: p = 3;
          1: p = 5;
          2: p = 7;
          3: p = 11;
          default: p = 13;
        endcase
        kmax = 32'h7FFF_FFFF / p;
        k = ($urandom_range(kmax, 1) - 1) | 1;
        v = p * k;
      end
      4, 5: v = $urandom_range(255);
      default: v = $urandom_range(65535) | 1;
    endcase
    return v;
  endfunction

  task automatic offer_candidate(input logic [DW-1:0] cand, input bit typed, input bit verdict);
    verdict_t v;
    v.cand = cand;
    v.is_prime = typed ? verdict : trial_divide_verdict(cand);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata = $urandom();
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = cand;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_verdicts.push_back(v);
    @(negedge clk);
  endtask

  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    verdict_t head;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result transaction: expected none, actual out_tdata=%0h",
                 $time, out_tdata);
        mismatch_count++;
      end else begin
        head = pending_verdicts.pop_front();
        if (out_tdata !== {7'd0, head.is_prime}) begin
          $display("%0t: candidate %0d: expected out_tdata=%0h, actual out_tdata=%0h",
                   $time, $signed(head.cand), {7'd0, head.is_prime}, out_tdata);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("FAIL trial_division_prime_test");
    $finish;
  end

  initial begin
    int idle_by_phase[N_PHASES];
    int stall_by_phase[N_PHASES];
    idle_by_phase = '{0, 47, 0, 12};
    stall_by_phase = '{0, 0, 47, 12};
    directed_probes = '{
      '{32'h0000_0000, 1'b1, 1'b0},
      '{32'h0000_0001, 1'b1, 1'b0},
      '{32'h0000_0002, 1'b1, 1'b1},
      '{32'h0000_0003, 1'b0, 1'b0},
      '{32'h0000_0004, 1'b1, 1'b0},
      '{32'h0000_0005, 1'b0, 1'b0},
      '{32'h0000_0009, 1'b0, 1'b0},
      '{32'h0000_000F, 1'b0, 1'b0},
      '{32'h0000_0019, 1'b0, 1'b0},
      '{32'h0000_0031, 1'b0, 1'b0},
      '{32'h0000_0061, 1'b0, 1'b0},
      '{32'h0000_FFF1, 1'b0, 1'b0},
      '{32'h000F_88E1, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 1'b0},
      '{32'h8000_0000, 1'b1, 1'b0},
      '{32'h8000_0001, 1'b1, 1'b0},
      '{32'hFFFF_FFFE, 1'b1, 1'b0},
      '{32'hAAAA_AAAA, 1'b1, 1'b0},
      '{32'h7FFF_FFFE, 1'b1, 1'b0},
      '{32'h7FFF_FFFD, 1'b0, 1'b0},
      '{32'h5555_5555, 1'b0, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      send_idle_pct = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      if (ph == 0) begin
        for (int i = 0; i < N_DIRECTED; i++) begin
          offer_candidate(directed_probes[i].cand, directed_probes[i].typed,
                          directed_probes[i].verdict);
        end
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        offer_candidate(random_candidate(), 1'b0, 1'b0);
      end
      // hold off until every result of this phase is back
      in_tvalid = 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("PASS trial_division_prime_test");
    end else begin
      $display("FAIL trial_division_prime_test");
    end
    $finish;
  end

endmodule
